@@ sv/sorted_timer_queue_macros.svh @@
// Assertion macros used by the sorted timer queue module.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STQ_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("timer queue check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define STQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("timer queue check failed");

`endif

@@ sv/stq_pkg.sv @@
// Shared codes and types of the sorted timer queue.
package stq_pkg;

	// Request operations.
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_ALLOC   = 3'd1;
	localparam logic [2:0] OP_REARM   = 3'd2;
	localparam logic [2:0] OP_DISARM  = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;

	// Timer kinds.
	localparam logic [1:0] KIND_REL = 2'd0;
	localparam logic [1:0] KIND_ABS = 2'd1;

	// Result kinds.
	localparam logic [1:0] RES_DONE    = 2'd0;
	localparam logic [1:0] RES_EXPIRED = 2'd1;
	localparam logic [1:0] RES_ERROR   = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NO_FREE   = 2'd1;
	localparam logic [1:0] ERR_BAD_KIND  = 2'd2;
	localparam logic [1:0] ERR_BAD_STATE = 2'd3;

	// Slot states.
	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ARMED = 2'd1;
	localparam logic [1:0] ST_HELD  = 2'd2;

	// Most expirations one tick may report.
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// Commands broadcast to every list cell.
	localparam logic [1:0] CMD_HOLD   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;
	localparam logic [1:0] CMD_DROP   = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
	} cell_ctl_t;

endpackage

@@ sv/stq_cell.sv @@
// One cell of the sorted list: holds one armed timer and trades with its neighbors.
module stq_cell #(
	parameter int TIME_BITS = 64,
	parameter int SLOT_W    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stq_pkg::cell_ctl_t    ctl,
	input  logic [TIME_BITS-1:0]  key_fire,
	input  logic [SLOT_W-1:0]     key_slot,
	input  logic                  prv_valid,
	input  logic [SLOT_W-1:0]     prv_slot,
	input  logic [TIME_BITS-1:0]  prv_fire,
	input  logic                  prv_le,
	input  logic                  nxt_valid,
	input  logic [SLOT_W-1:0]     nxt_slot,
	input  logic [TIME_BITS-1:0]  nxt_fire,
	input  logic                  hit_in,
	output logic                  cur_valid,
	output logic [SLOT_W-1:0]     cur_slot,
	output logic [TIME_BITS-1:0]  cur_fire,
	output logic                  le,
	output logic                  hit_out,
	output logic                  mine
);
	import stq_pkg::*;

	logic                 valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [TIME_BITS-1:0] fire_q;
	logic                 valid_d;
	logic [SLOT_W-1:0]    slot_d;
	logic [TIME_BITS-1:0] fire_d;

	// Local compares against the broadcast key.
	assign le      = valid_q && (fire_q <= key_fire);
	assign mine    = valid_q && (slot_q == key_slot);
	assign hit_out = hit_in | mine;

	// Next contents: keep, take the new timer, or shift from a neighbor.
	always_comb begin
		valid_d = valid_q;
		slot_d  = slot_q;
		fire_d  = fire_q;
		case (ctl.cmd)
			CMD_INSERT: begin
				if (!le) begin
					if (prv_le) begin
						valid_d = 1'b1;
						slot_d  = key_slot;
						fire_d  = key_fire;
					end else begin
						valid_d = prv_valid;
						slot_d  = prv_slot;
						fire_d  = prv_fire;
					end
				end
			end
			CMD_POP: begin
				valid_d = nxt_valid;
				slot_d  = nxt_slot;
				fire_d  = nxt_fire;
			end
			CMD_DROP: begin
				if (hit_out) begin
					valid_d = nxt_valid;
					slot_d  = nxt_slot;
					fire_d  = nxt_fire;
				end
			end
			default: begin
				valid_d = valid_q;
			end
		endcase
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Timer payload.
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		fire_q <= fire_d;
	end

	assign cur_valid = valid_q;
	assign cur_slot  = slot_q;
	assign cur_fire  = fire_q;

endmodule

@@ sv/sorted_timer_queue.sv @@
// A command's result is formed in the execute state and enters the output register when that register is free.
// A tick advances the tick count in the execute state; its results then enter it from the expire state,
// one result per cycle while the output register is not stalled.
// A stalled output register holds the sequencer; no new request is taken until the sequencer is idle.
// Reset empties the list, stacks every slot as free, clears the tick count, sets free_on_fire.
module sorted_timer_queue #(
	parameter int NUM_SLOTS = 16,
	parameter int TIME_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [1:0]  timer_kind,
	input  logic [63:0] fire_time,
	input  logic [3:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [1:0]  error_code,
	output logic [3:0]  result_slot,
	output logic [63:0] result_fire,
	output logic [63:0] tick_now,
	output logic        last
);
	import stq_pkg::*;

	`include "sorted_timer_queue_macros.svh"

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_EXP  = 2'd2;

	logic [1:0]           state_q;
	logic                 free_on_fire_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [2:0]           op_q;
	logic [1:0]           kind_q;
	logic [TIME_BITS-1:0] ft_q;
	logic [3:0]           slot_q;
	logic [RES_CNT_W-1:0] n_q;
	logic [SLOT_W-1:0]    free_stack_q [NUM_SLOTS];
	logic [CNT_W-1:0]     free_cnt_q;
	logic [1:0]           slot_status_q [NUM_SLOTS];

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [1:0]           out_err_q;
	logic [3:0]           out_slot_q;
	logic [TIME_BITS-1:0] out_fire_q;
	logic [TIME_BITS-1:0] out_tick_q;
	logic                 out_last_q;

	// Cell row signals.
	logic                 cv   [NUM_SLOTS];
	logic [SLOT_W-1:0]    cs   [NUM_SLOTS];
	logic [TIME_BITS-1:0] cf   [NUM_SLOTS];
	logic                 cle  [NUM_SLOTS];
	logic                 chit [NUM_SLOTS];
	logic                 cmine[NUM_SLOTS];
	cell_ctl_t            ctl;
	logic [TIME_BITS-1:0] key_fire;
	logic [SLOT_W-1:0]    key_slot;

	// Decode helpers.
	logic                 in_accept;
	logic                 out_free;
	logic [SLOT_W-1:0]    s_idx;
	logic                 s_ok;
	logic [1:0]           s_state;
	logic [SLOT_W-1:0]    top_slot;
	logic [TIME_BITS-1:0] arm_fire;
	logic [TIME_BITS-1:0] drop_fire;
	logic                 due0;
	logic                 due1;

	// Sequencer outputs.
	logic [1:0]           state_d;
	logic                 emit;
	logic [1:0]           e_kind;
	logic [1:0]           e_err;
	logic [3:0]           e_slot;
	logic [TIME_BITS-1:0] e_fire;
	logic                 e_last;
	logic                 tick_inc;
	logic                 n_clr;
	logic                 n_inc;
	logic                 pop_free;
	logic                 push_free;
	logic [SLOT_W-1:0]    push_slot;
	logic                 st_we;
	logic [SLOT_W-1:0]    st_idx;
	logic [1:0]           st_val;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign s_idx    = SLOT_W'(slot_q);
	assign s_ok     = (32'(slot_q) < 32'(NUM_SLOTS));
	assign s_state  = slot_status_q[s_idx];
	assign top_slot = free_stack_q[SLOT_W'(free_cnt_q - 1'b1)];
	assign arm_fire = (kind_q == KIND_REL) ? (ft_q + tick_q) : ft_q;

	// Head compares against the tick count.
	assign due0 = cv[0] && (cf[0] <= tick_q);
	generate
		if (NUM_SLOTS > 1) begin : g_due1
			assign due1 = cv[1] && (cf[1] <= tick_q);
		end else begin : g_due1_none
			assign due1 = 1'b0;
		end
	endgenerate

	// Fire time of the cell holding the addressed slot.
	always_comb begin
		drop_fire = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (cmine[i]) begin
				drop_fire = drop_fire | cf[i];
			end
		end
	end

	// The row of list cells.
	generate
		for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
			logic                 p_valid;
			logic [SLOT_W-1:0]    p_slot;
			logic [TIME_BITS-1:0] p_fire;
			logic                 p_le;
			logic                 p_hit;
			logic                 n_valid;
			logic [SLOT_W-1:0]    n_slot;
			logic [TIME_BITS-1:0] n_fire;
			if (i == 0) begin : g_first
				assign p_valid = 1'b0;
				assign p_slot  = '0;
				assign p_fire  = '0;
				assign p_le    = 1'b1;
				assign p_hit   = 1'b0;
			end else begin : g_mid
				assign p_valid = cv[i-1];
				assign p_slot  = cs[i-1];
				assign p_fire  = cf[i-1];
				assign p_le    = cle[i-1];
				assign p_hit   = chit[i-1];
			end
			if (i == NUM_SLOTS - 1) begin : g_last
				assign n_valid = 1'b0;
				assign n_slot  = '0;
				assign n_fire  = '0;
			end else begin : g_inner
				assign n_valid = cv[i+1];
				assign n_slot  = cs[i+1];
				assign n_fire  = cf[i+1];
			end
			stq_cell #(
				.TIME_BITS (TIME_BITS),
				.SLOT_W    (SLOT_W)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.key_fire  (key_fire),
				.key_slot  (key_slot),
				.prv_valid (p_valid),
				.prv_slot  (p_slot),
				.prv_fire  (p_fire),
				.prv_le    (p_le),
				.nxt_valid (n_valid),
				.nxt_slot  (n_slot),
				.nxt_fire  (n_fire),
				.hit_in    (p_hit),
				.cur_valid (cv[i]),
				.cur_slot  (cs[i]),
				.cur_fire  (cf[i]),
				.le        (cle[i]),
				.hit_out   (chit[i]),
				.mine      (cmine[i])
			);
		end
	endgenerate

	// Sequencer: runs one request and its results.
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		e_kind    = RES_DONE;
		e_err     = ERR_NONE;
		e_slot    = '0;
		e_fire    = '0;
		e_last    = 1'b1;
		tick_inc  = 1'b0;
		n_clr     = 1'b0;
		n_inc     = 1'b0;
		pop_free  = 1'b0;
		push_free = 1'b0;
		push_slot = s_idx;
		st_we     = 1'b0;
		st_idx    = s_idx;
		st_val    = ST_FREE;
		ctl.cmd   = CMD_HOLD;
		key_fire  = arm_fire;
		key_slot  = s_idx;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == OP_TICK) begin
					tick_inc = 1'b1;
					n_clr    = 1'b1;
					state_d  = S_EXP;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					case (op_q)
						OP_ALLOC: begin
							if (kind_q != KIND_REL && kind_q != KIND_ABS) begin
								e_kind = RES_ERROR;
								e_err  = ERR_BAD_KIND;
							end else if (free_cnt_q == '0) begin
								e_kind = RES_ERROR;
								e_err  = ERR_NO_FREE;
							end else begin
								pop_free = 1'b1;
								key_slot = top_slot;
								ctl.cmd  = CMD_INSERT;
								st_we    = 1'b1;
								st_idx   = top_slot;
								st_val   = ST_ARMED;
								e_slot   = 4'(top_slot);
								e_fire   = arm_fire;
							end
						end
						OP_REARM: begin
							e_slot = slot_q;
							if (kind_q != KIND_REL && kind_q != KIND_ABS) begin
								e_kind = RES_ERROR;
								e_err  = ERR_BAD_KIND;
							end else if (!s_ok || s_state != ST_HELD) begin
								e_kind = RES_ERROR;
								e_err  = ERR_BAD_STATE;
							end else begin
								ctl.cmd = CMD_INSERT;
								st_we   = 1'b1;
								st_val  = ST_ARMED;
								e_fire  = arm_fire;
							end
						end
						OP_DISARM: begin
							e_slot = slot_q;
							if (!s_ok || s_state != ST_ARMED) begin
								e_kind = RES_ERROR;
								e_err  = ERR_BAD_STATE;
							end else begin
								ctl.cmd = CMD_DROP;
								st_we   = 1'b1;
								st_val  = ST_HELD;
								e_fire  = drop_fire;
							end
						end
						OP_RELEASE: begin
							e_slot = slot_q;
							if (!s_ok || s_state != ST_HELD) begin
								e_kind = RES_ERROR;
								e_err  = ERR_BAD_STATE;
							end else begin
								push_free = 1'b1;
								st_we     = 1'b1;
								st_val    = ST_FREE;
							end
						end
						default: begin
							e_kind = RES_DONE;
						end
					endcase
				end
			end
			S_EXP: begin
				if (out_free) begin
					emit = 1'b1;
					if (due0 && (n_q < RES_CNT_W'(MAX_RESULTS))) begin
						ctl.cmd   = CMD_POP;
						n_inc     = 1'b1;
						e_kind    = RES_EXPIRED;
						e_slot    = 4'(cs[0]);
						e_fire    = cf[0];
						e_last    = (n_q == RES_CNT_W'(MAX_RESULTS - 1)) || !due1;
						st_we     = 1'b1;
						st_idx    = cs[0];
						st_val    = free_on_fire_q ? ST_FREE : ST_HELD;
						push_free = free_on_fire_q;
						push_slot = cs[0];
					end
					if (e_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state: sequencer, tick count, register, counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			free_on_fire_q <= 1'b1;
			tick_q         <= '0;
			n_q            <= '0;
			free_cnt_q     <= CNT_W'(NUM_SLOTS);
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				free_on_fire_q <= cfg_wdata;
			end
			if (tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end
			if (n_clr) begin
				n_q <= '0;
			end else if (n_inc) begin
				n_q <= n_q + 1'b1;
			end
			if (pop_free) begin
				free_cnt_q <= free_cnt_q - 1'b1;
			end else if (push_free && free_cnt_q < CNT_W'(NUM_SLOTS)) begin
				free_cnt_q <= free_cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Free slot stack and slot states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				free_stack_q[i]  <= SLOT_W'(i);
				slot_status_q[i] <= ST_FREE;
			end
		end else begin
			if (push_free && free_cnt_q < CNT_W'(NUM_SLOTS)) begin
				free_stack_q[SLOT_W'(free_cnt_q)] <= push_slot;
			end
			if (st_we) begin
				slot_status_q[st_idx] <= st_val;
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= operation;
			kind_q <= timer_kind;
			ft_q   <= fire_time[TIME_BITS-1:0];
			slot_q <= slot;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= e_kind;
			out_err_q  <= e_err;
			out_slot_q <= e_slot;
			out_fire_q <= e_fire;
			out_tick_q <= tick_q;
			out_last_q <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign error_code  = out_err_q;
	assign result_slot = out_slot_q;
	assign result_fire = 64'(out_fire_q);
	assign tick_now    = 64'(out_tick_q);
	assign last        = out_last_q;

	// Checks on the free count, the sequencer and the list order.
	`STQ_ASSERT_NOW(a_free_bound, 1'b1, free_cnt_q <= CNT_W'(NUM_SLOTS))
	`STQ_ASSERT_NEXT(a_accept_exec, in_accept, state_q == S_EXEC)
	generate
		if (NUM_SLOTS > 1) begin : g_order_chk
			`STQ_ASSERT_NOW(a_head_order, cv[1], cv[0] && (cf[0] <= cf[1]))
		end
	endgenerate

endmodule
